/* design/lcdf_pkg.sv */
package lcdf_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int VALUE_W = 64;
  localparam int CELL_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int WRAP_W  = 7;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [OP_W-1:0] OP_CHAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_GOTO  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
  localparam logic [OP_W-1:0] OP_HEX   = 3'd4;
  localparam logic [OP_W-1:0] OP_BIN   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] CLEAR_CMD_RST = 8'h01;
  localparam logic [WRAP_W-1:0] WRAP_COL_RST  = 7'd16;

  // LCD instruction bits and character codes
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
  localparam logic [BYTE_W-1:0] LINE1_OFFSET = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A       = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SEND
  } state_t;

  // Status from the BCD converter
  typedef struct packed {
    logic done;
    logic ovf;
  } conv_stat_t;

  // ASCII glyph of one hex digit
  function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
    logic [BYTE_W-1:0] r;
    if (d <= 4'd9) begin
      r = CHAR_ZERO + {4'd0, d};
    end else begin
      r = CHAR_A + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

  // Spread 8 bits into 8 nibbles, bit 7 in the top nibble
  function automatic logic [31:0] bin_nibbles(input logic [7:0] b);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i] = b[i];
    end
    return r;
  endfunction

endpackage

/* design/lcdf_cmd_if.sv */
interface lcdf_cmd_if import lcdf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic                      line;
  logic [CELL_W-1:0]         cell_req;

  modport source (output valid, operation, value, line, cell_req, input ready);
  modport sink   (input valid, operation, value, line, cell_req, output ready);
endinterface

/* design/lcdf_bus_if.sv */
interface lcdf_bus_if import lcdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reg_select;
  logic [BYTE_W-1:0] bus_value;
  logic              last;

  modport source (output valid, reg_select, bus_value, last, input ready);
  modport sink   (input valid, reg_select, bus_value, last, output ready);
endinterface

/* design/lcdf_cfg_if.sv */
interface lcdf_cfg_if import lcdf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/lcdf_bcd_conv.sv */
// Binary to BCD converter, shift-and-add-3, one input bit per cycle.
// Keeps the low MAX_DIGITS digits; ovf flags a value of 10**MAX_DIGITS or more.
module lcdf_bcd_conv import lcdf_pkg::*; #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_W-1:0]      mag,
  output logic [4*MAX_DIGITS-1:0] bcd,
  output conv_stat_t              stat
);

  localparam int BW    = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic [VALUE_W-1:0] shreg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic               ovf;
  logic [BW-1:0]      adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      ovf  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_W);
        ovf  <= 1'b0;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        ovf <= ovf | adj[BW-1];
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag;
      bcd   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {adj[BW-2:0], shreg[VALUE_W-1]};
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("converter restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("converter busy with zero count");

endmodule

/* design/char_lcd_text_formatter.sv */
// Character-LCD text formatter.
// cmd (sink): one command per request: character, goto, clear, signed decimal,
//   hex of the low 32 bits or binary of the low 8 bits. cmd.ready is high only
//   while the sequencer is idle; one command is handled at a time.
// bus (source): LCD bus transfers, reg_select 0 for instruction, 1 for data,
//   last marks the final transfer of a command. In nibble mode a byte goes
//   out as two transfers, high nibble first, in bus_value[3:0].
// cfg (sink): register writes, always ready; write only while idle.
// Order of work per request with no stall: a character, goto or clear is
//   loaded and then sent one transfer at a time. Decimal runs the 64-step
//   shift-and-add-3 conversion and handoff, drops each suppressed leading
//   zero and then sends. Hex and binary drop suppressed zeros, then send.
//   The next command is accepted in the cycle after the last
//   transfer enters the output register.
// A bus stall holds the output register; the sequencer waits on it.
// Reset: cursor to line 0, cell 0, registers to nibble_mode 0,
//   clear_command 0x01, wrap_column 16; no request in flight.
module char_lcd_text_formatter import lcdf_pkg::*; #(
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  lcdf_cmd_if.sink    cmd,
  lcdf_bus_if.source  bus,
  lcdf_cfg_if.sink    cfg
);

  localparam int BW   = 4 * MAX_DIGITS;
  localparam int NBUF = (MAX_DIGITS > 8) ? MAX_DIGITS : 8;
  localparam int DBW  = 4 * NBUF;
  localparam int CW   = $clog2(NBUF + 1);

  // Configuration registers
  logic              nib_mode;
  logic [BYTE_W-1:0] clear_cmd;
  logic [WRAP_W-1:0] wrap_col;

  // Sequencer registers
  state_t            state, state_next;
  logic              cur_rs, cur_rs_next;
  logic [BYTE_W-1:0] cur_byte, cur_byte_next;
  logic              lo_phase, lo_phase_next;
  logic [DBW-1:0]    dbuf, dbuf_next;
  logic [CW-1:0]     ndig, ndig_next;
  logic [CW-1:0]     n_min, n_min_next;
  logic              neg, neg_next;
  logic              cursor_line, cursor_line_next;
  logic [7:0]        cursor_cell, cursor_cell_next;

  // Output register
  logic              out_valid, out_valid_next;
  logic              out_rs, out_rs_next;
  logic [BYTE_W-1:0] out_val, out_val_next;
  logic              out_last, out_last_next;

  // Converter
  logic               conv_start;
  logic [VALUE_W-1:0] conv_mag;
  logic [BW-1:0]      conv_bcd;
  conv_stat_t         conv_stat;

  logic              cmd_take;
  logic              slot_free;
  logic              src_has;
  logic [BYTE_W-1:0] src_byte;
  logic              take_src;
  logic [7:0]        cell_inc;
  logic              wrap_hit;
  logic              more;
  logic              byte_fin;

  lcdf_bcd_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .mag   (conv_mag),
    .bcd   (conv_bcd),
    .stat  (conv_stat)
  );

  // Handshakes
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign slot_free = !out_valid || bus.ready;

  assign bus.valid      = out_valid;
  assign bus.reg_select = out_rs;
  assign bus.bus_value  = out_val;
  assign bus.last       = out_last;

  // Magnitude of the decimal operand, unsigned
  assign conv_mag = cmd.value[VALUE_W-1] ? (~cmd.value) + 64'd1 : cmd.value;

  // Next character source: pending sign, then digits from the top of dbuf
  assign src_has  = neg || (ndig != '0);
  assign src_byte = neg ? CHAR_MINUS : digit_char(dbuf[DBW-1 -: 4]);

  // Cursor advance and wrap check for the data byte in flight
  assign cell_inc = cursor_cell + 8'd1;
  assign wrap_hit = cur_rs && !cursor_line && (cell_inc == {1'b0, wrap_col});
  assign more     = wrap_hit || src_has;
  assign byte_fin = (state == ST_SEND) && slot_free && (!nib_mode || lo_phase);

  // Next state and datapath
  always_comb begin
    state_next       = state;
    cur_rs_next      = cur_rs;
    cur_byte_next    = cur_byte;
    lo_phase_next    = lo_phase;
    dbuf_next        = dbuf;
    ndig_next        = ndig;
    n_min_next       = n_min;
    neg_next         = neg;
    cursor_line_next = cursor_line;
    cursor_cell_next = cursor_cell;
    out_valid_next   = slot_free ? 1'b0 : out_valid;
    out_rs_next      = out_rs;
    out_val_next     = out_val;
    out_last_next    = out_last;
    conv_start       = 1'b0;
    take_src         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          neg_next      = 1'b0;
          ndig_next     = '0;
          n_min_next    = '0;
          lo_phase_next = 1'b0;
          unique case (cmd.operation)
            OP_CHAR: begin
              cur_rs_next   = 1'b1;
              cur_byte_next = cmd.value[7:0];
              state_next    = ST_SEND;
            end
            OP_GOTO: begin
              cur_rs_next      = 1'b0;
              cur_byte_next    = CMD_SET_ADDR | (cmd.line ? LINE1_OFFSET : 8'd0)
                                 | {2'b00, cmd.cell_req};
              cursor_line_next = cmd.line;
              cursor_cell_next = {2'b00, cmd.cell_req};
              state_next       = ST_SEND;
            end
            OP_CLEAR: begin
              cur_rs_next      = 1'b0;
              cur_byte_next    = clear_cmd;
              cursor_line_next = 1'b0;
              cursor_cell_next = 8'd0;
              state_next       = ST_SEND;
            end
            OP_DEC: begin
              conv_start = 1'b1;
              neg_next   = cmd.value[VALUE_W-1];
              state_next = ST_CONV;
            end
            OP_HEX: begin
              dbuf_next  = DBW'(cmd.value[31:0]) << (DBW - 32);
              ndig_next  = CW'(8);
              state_next = ST_TRIM;
            end
            OP_BIN: begin
              dbuf_next  = DBW'(bin_nibbles(cmd.value[7:0])) << (DBW - 32);
              ndig_next  = CW'(8);
              state_next = ST_TRIM;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONV: begin
        if (conv_stat.done) begin
          dbuf_next  = DBW'(conv_bcd) << (DBW - BW);
          ndig_next  = CW'(MAX_DIGITS);
          n_min_next = conv_stat.ovf ? CW'(MAX_DIGITS) : CW'(1);
          state_next = ST_TRIM;
        end
      end

      // Drop leading zero digits, one per cycle
      ST_TRIM: begin
        if ((ndig > n_min) && (dbuf[DBW-1 -: 4] == 4'd0)) begin
          dbuf_next = dbuf << 4;
          ndig_next = ndig - 1'b1;
        end else if (src_has) begin
          take_src   = 1'b1;
          state_next = ST_SEND;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_SEND: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_rs_next    = cur_rs;
          if (nib_mode && !lo_phase) begin
            out_val_next  = {4'd0, cur_byte[7:4]};
            out_last_next = 1'b0;
            lo_phase_next = 1'b1;
          end else begin
            out_val_next  = nib_mode ? {4'd0, cur_byte[3:0]} : cur_byte;
            out_last_next = !more;
            lo_phase_next = 1'b0;
            if (cur_rs) begin
              cursor_cell_next = cell_inc;
            end
            if (wrap_hit) begin
              cursor_line_next = 1'b1;
              cursor_cell_next = 8'd0;
              cur_rs_next      = 1'b0;
              cur_byte_next    = CMD_SET_ADDR | LINE1_OFFSET;
            end else if (src_has) begin
              take_src = 1'b1;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
    endcase

    // Pull the next character from the sign flag or the digit buffer
    if (take_src) begin
      cur_rs_next   = 1'b1;
      cur_byte_next = src_byte;
      if (neg) begin
        neg_next = 1'b0;
      end else begin
        dbuf_next = dbuf << 4;
        ndig_next = ndig - 1'b1;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_phase    <= 1'b0;
      ndig        <= '0;
      n_min       <= '0;
      neg         <= 1'b0;
      cursor_line <= 1'b0;
      cursor_cell <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      lo_phase    <= lo_phase_next;
      ndig        <= ndig_next;
      n_min       <= n_min_next;
      neg         <= neg_next;
      cursor_line <= cursor_line_next;
      cursor_cell <= cursor_cell_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_rs   <= cur_rs_next;
    cur_byte <= cur_byte_next;
    dbuf     <= dbuf_next;
    out_rs   <= out_rs_next;
    out_val  <= out_val_next;
    out_last <= out_last_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nib_mode  <= 1'b0;
      clear_cmd <= CLEAR_CMD_RST;
      wrap_col  <= WRAP_COL_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_NIBBLE: nib_mode  <= cfg.data[0];
        CFG_CLEAR:  clear_cmd <= cfg.data;
        CFG_WRAP:   wrap_col  <= cfg.data[WRAP_W-1:0];
        default:    ;
      endcase
    end
  end

  // Checks
  a_load_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SEND))
    else $error("transfer loaded outside the send state");
  a_last_ends_cmd: assert property (@(posedge clk) disable iff (rst)
    (byte_fin && !more) |=> (state == ST_IDLE) && out_last && out_valid)
    else $error("final transfer did not end the request");
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !lo_phase)
    else $error("ready with a half-sent byte");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdf_pkg::*;

  // Decimal digit limit handed to the block
  localparam int DIGIT_LIMIT = 20;
  // Unused command codes: the block sends nothing for these
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  // Cycles allowed for a command that sends nothing to finish
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic                      line;
    logic [CELL_W-1:0]         cell_pos;
  } lcd_cmd_t;

  typedef struct {
    logic              rs;
    logic [BYTE_W-1:0] data;
    logic              last;
  } lcd_xfer_t;

  logic clk = 1'b0;
  logic rst;

  lcdf_cmd_if cmd_ch ();
  lcdf_bus_if bus_ch ();
  lcdf_cfg_if cfg_ch ();

  char_lcd_text_formatter #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .bus (bus_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // Commands waiting for the driver, transfers waiting for the bus
  lcd_cmd_t  cmd_backlog[$];
  lcd_xfer_t lcd_xfer_q[$];
  lcd_xfer_t burst[$];

  // Shadow of the block's registers and cursor
  logic              nib_mode;
  logic [BYTE_W-1:0] clr_byte;
  logic [WRAP_W-1:0] wrap_at;
  logic              cur_line;
  logic [7:0]        cur_cell;

  bit quiet;
  int mismatches;
  int cmds_done;
  int xfers_seen;
  int wraps;
  int reg_writes;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic bit take_gap();
    return !quiet && ($urandom_range(0, 99) < 11);
  endfunction

  // ---------------- transfer predictor ----------------

  function automatic void send_lcd_byte(logic rs, logic [BYTE_W-1:0] b);
    lcd_xfer_t x;
    x.rs   = rs;
    x.last = 1'b0;
    if (nib_mode) begin
      x.data = {4'h0, b[7:4]};
      burst.push_back(x);
      x.data = {4'h0, b[3:0]};
      burst.push_back(x);
    end else begin
      x.data = b;
      burst.push_back(x);
    end
  endfunction

  function automatic void move_cursor(logic ln, logic [CELL_W-1:0] pos);
    cur_line = ln;
    cur_cell = {2'b00, pos};
    send_lcd_byte(1'b0, CMD_SET_ADDR + {2'b00, pos} + (ln ? LINE1_OFFSET : 8'h00));
  endfunction

  // Data character, then the wrap check on the top line
  function automatic void write_glyph(logic [BYTE_W-1:0] ch);
    send_lcd_byte(1'b1, ch);
    cur_cell = cur_cell + 8'd1;
    if (!cur_line && cur_cell == {1'b0, wrap_at}) begin
      wraps++;
      move_cursor(1'b1, '0);
    end
  endfunction

  function automatic void print_decimal(logic [VALUE_W-1:0] raw);
    logic [3:0]         digs [DIGIT_LIMIT];
    logic [VALUE_W-1:0] mag;
    int                 n;
    mag = raw;
    n   = 0;
    // magnitude as unsigned, so the most negative value works
    if (raw[VALUE_W-1]) begin
      write_glyph(CHAR_MINUS);
      mag = ~raw + 64'd1;
    end
    if (mag == 0) begin
      digs[0] = 4'd0;
      n = 1;
    end
    while (mag != 0 && n < DIGIT_LIMIT) begin
      digs[n] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      n++;
    end
    while (n > 0) begin
      n--;
      write_glyph(CHAR_ZERO + {4'h0, digs[n]});
    end
  endfunction

  // Leading zeros dropped; zero prints nothing
  function automatic void print_hex(logic [31:0] v);
    logic [3:0] d;
    logic       seen;
    seen = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      d = v[4*i +: 4];
      if (d != 4'd0 || seen) begin
        write_glyph((d <= 4'd9) ? CHAR_ZERO + {4'h0, d} : CHAR_A + {4'h0, d} - 8'd10);
        seen = 1'b1;
      end
    end
  endfunction

  function automatic void print_binary(logic [7:0] v);
    logic seen;
    seen = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i] || seen) begin
        write_glyph(v[i] ? CHAR_ZERO + 8'd1 : CHAR_ZERO);
        seen = 1'b1;
      end
    end
  endfunction

  function automatic void predict_transfers(lcd_cmd_t c);
    lcd_xfer_t x;
    burst.delete();
    case (c.op)
      OP_CHAR:  write_glyph(c.value[7:0]);
      OP_GOTO:  move_cursor(c.line, c.cell_pos);
      OP_CLEAR: begin
        send_lcd_byte(1'b0, clr_byte);
        cur_line = 1'b0;
        cur_cell = 8'd0;
      end
      OP_DEC:   print_decimal(c.value);
      OP_HEX:   print_hex(c.value[31:0]);
      OP_BIN:   print_binary(c.value[7:0]);
      default:  ;
    endcase
    if (burst.size() > 0) begin
      x = burst[burst.size()-1];
      x.last = 1'b1;
      burst[burst.size()-1] = x;
    end
    foreach (burst[i]) lcd_xfer_q.push_back(burst[i]);
  endfunction

  // ---------------- command driver ----------------

  always @(posedge clk) begin
    lcd_cmd_t got;
    lcd_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its transfers
      if (cmd_ch.valid && cmd_ch.ready) begin
        got.op       = cmd_ch.operation;
        got.value    = cmd_ch.value;
        got.line     = cmd_ch.line;
        got.cell_pos = cmd_ch.cell_req;
        predict_transfers(got);
        cmds_done++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && !take_gap()) begin
          nxt = cmd_backlog.pop_front();
          cmd_ch.valid     <= 1'b1;
          cmd_ch.operation <= nxt.op;
          cmd_ch.value     <= nxt.value;
          cmd_ch.line      <= nxt.line;
          cmd_ch.cell_req  <= nxt.cell_pos;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- bus monitor ----------------

  always @(posedge clk) begin
    lcd_xfer_t want;
    if (rst) begin
      bus_ch.ready <= 1'b0;
    end else begin
      if (bus_ch.valid && bus_ch.ready) begin
        if (lcd_xfer_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer rs=%0b value=%02h last=%0b",
                                    bus_ch.reg_select, bus_ch.bus_value, bus_ch.last));
        end else begin
          want = lcd_xfer_q.pop_front();
          xfers_seen++;
          if (bus_ch.reg_select !== want.rs)
            report_mismatch($sformatf("transfer %0d reg_select %0b, want %0b",
                                      xfers_seen, bus_ch.reg_select, want.rs));
          if (bus_ch.bus_value !== want.data)
            report_mismatch($sformatf("transfer %0d bus_value %02h, want %02h",
                                      xfers_seen, bus_ch.bus_value, want.data));
          if (bus_ch.last !== want.last)
            report_mismatch($sformatf("transfer %0d last %0b, want %0b",
                                      xfers_seen, bus_ch.last, want.last));
        end
      end
      bus_ch.ready <= !take_gap();
    end
  end

  // ---------------- stimulus ----------------

  function automatic void add_cmd(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                  logic line, logic [CELL_W-1:0] pos);
    lcd_cmd_t c;
    c.op       = op;
    c.value    = value;
    c.line     = line;
    c.cell_pos = pos;
    cmd_backlog.push_back(c);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 255));
      2: v = 64'd0 - 64'($urandom_range(1, 99999));
      3: v = {$urandom, 32'($urandom_range(0, 4095))};
      default: begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly printing and character commands, a few resets of the cursor,
  // and some unused codes as noise
  function automatic void queue_random(int count);
    int pick;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_CHAR;
      else if (pick < 40) op = OP_GOTO;
      else if (pick < 45) op = OP_CLEAR;
      else if (pick < 65) op = OP_DEC;
      else if (pick < 80) op = OP_HEX;
      else if (pick < 95) op = OP_BIN;
      else                op = $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;
      add_cmd(op, random_value(), 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    end
  endfunction

  // Wait until the backlog and the expected transfers are both empty,
  // then give a silent command time to finish
  task automatic settle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || lcd_xfer_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_NIBBLE: nib_mode = d[0];
      CFG_CLEAR:  clr_byte = d;
      CFG_WRAP:   wrap_at  = d[WRAP_W-1:0];
      default:    ;
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_CHAR;
    cmd_ch.value     = '0;
    cmd_ch.line      = 1'b0;
    cmd_ch.cell_req  = '0;
    bus_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_NIBBLE;
    cfg_ch.data      = '0;
    nib_mode = 1'b0;
    clr_byte = CLEAR_CMD_RST;
    wrap_at  = WRAP_COL_RST;
    cur_line = 1'b0;
    cur_cell = 8'd0;
    quiet    = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes and every command at reset settings
    add_cmd(OP_CHAR,  64'h0000_0000_0000_0000, 1'b0, 6'd0);
    add_cmd(OP_CHAR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63);
    add_cmd(OP_GOTO,  64'd0, 1'b1, 6'd63);
    add_cmd(OP_GOTO,  64'd0, 1'b0, 6'd63);
    add_cmd(OP_GOTO,  64'd0, 1'b1, 6'd0);
    add_cmd(OP_CLEAR, 64'd0, 1'b0, 6'd0);
    add_cmd(OP_DEC,   64'd0, 1'b0, 6'd0);
    add_cmd(OP_DEC,   64'd1, 1'b0, 6'd0);
    add_cmd(OP_DEC,   '1, 1'b0, 6'd0);
    add_cmd(OP_DEC,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);
    add_cmd(OP_DEC,   64'h8000_0000_0000_0000, 1'b0, 6'd0);
    add_cmd(OP_CLEAR, 64'd0, 1'b0, 6'd0);
    add_cmd(OP_HEX,   64'd0, 1'b0, 6'd0);
    add_cmd(OP_HEX,   64'h0000_0000_FFFF_FFFF, 1'b0, 6'd0);
    add_cmd(OP_HEX,   64'hDEAD_BEEF_0000_00A0, 1'b0, 6'd0);
    add_cmd(OP_BIN,   64'hFFFF_FFFF_FFFF_FF00, 1'b0, 6'd0);
    add_cmd(OP_BIN,   64'd255, 1'b0, 6'd0);
    add_cmd(OP_BIN,   64'd1, 1'b0, 6'd0);
    add_cmd(OP_RSVD6, '1, 1'b1, 6'd63);
    add_cmd(OP_RSVD7, '1, 1'b1, 6'd63);
    settle();

    // Nibble transfers, all-ones clear byte, wrap after one cell; no idling
    write_reg(CFG_NIBBLE, 8'd1);
    write_reg(CFG_CLEAR, 8'hFF);
    write_reg(CFG_WRAP, 8'd1);
    quiet = 1'b1;
    queue_random(45);
    settle();
    quiet = 1'b0;

    // Byte transfers, zero clear byte, widest legal wrap
    write_reg(CFG_NIBBLE, 8'd0);
    write_reg(CFG_CLEAR, 8'h00);
    write_reg(CFG_WRAP, 8'd64);
    queue_random(45);
    settle();

    // Wrap column zero: from cell 63 the cell runs past it and only the
    // 8-bit rollover brings the wrap
    write_reg(CFG_NIBBLE, 8'd1);
    write_reg(CFG_WRAP, 8'd0);
    add_cmd(OP_GOTO, 64'd0, 1'b0, 6'd63);
    for (int i = 0; i < 10; i++) add_cmd(OP_DEC, 64'h8000_0000_0000_0000, 1'b0, 6'd0);
    queue_random(30);
    settle();

    // Wrap column above the line length; index with no register is a no-op
    write_reg(CFG_NIBBLE, 8'd0);
    write_reg(CFG_CLEAR, 8'h5A);
    write_reg(CFG_WRAP, 8'd100);
    write_reg(CFG_NONE, 8'hA5);
    add_cmd(OP_GOTO, 64'd0, 1'b0, 6'd60);
    add_cmd(OP_DEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);
    add_cmd(OP_DEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);
    queue_random(40);
    settle();

    // Back to the reset values with nibble transfers on
    write_reg(CFG_NIBBLE, 8'd1);
    write_reg(CFG_CLEAR, CLEAR_CMD_RST);
    write_reg(CFG_WRAP, {1'b0, WRAP_COL_RST});
    queue_random(40);
    settle();

    $display("summary: %0d commands sent, %0d bus transfers checked, %0d line wraps",
             cmds_done, xfers_seen, wraps);
    $display("summary: %0d register writes, byte and nibble modes, wrap columns 0 to 100",
             reg_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far past the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout waiting for bus transfers");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
